### src/tva_pkg.sv
// ----------------------------------------------------------------------------
// tva_pkg: shared types and constants for the three-vector ALU
// Fixed-point format, command codes, the pipeline record and saturation helper.
// ----------------------------------------------------------------------------
package tva_pkg;

    // fixed-point format
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int WIDE_W     = 2 * DATA_W + 2;   // exact sums of products
    localparam int RAD_W      = 2 * DATA_W;       // radicand of the length
    localparam int ROOT_W     = DATA_W;
    localparam int ROOT_IDX_W = $clog2(ROOT_W);
    localparam int QUO_W      = FRAC_BITS + 1;    // |quotient| <= 2^FRAC_BITS
    localparam int DIV_IDX_W  = $clog2(QUO_W);
    localparam int DREM_W     = DATA_W + FRAC_BITS;
    localparam int LANES      = 3;

    typedef enum logic [2:0] {
        CMD_LENGTH    = 3'd0,
        CMD_NORMALIZE = 3'd1,
        CMD_DOT       = 3'd2,
        CMD_SCALE     = 3'd3,
        CMD_ADD       = 3'd4
    } cmd_t;

    // record that travels down the pipeline
    typedef struct packed {
        logic [2:0]                             cmd;
        logic [RAD_W-1:0]                       rad;
        logic [ROOT_W-1:0]                      root;
        logic [LANES-1:0][DATA_W-1:0]           mag;
        logic [LANES-1:0]                       neg;
        logic [LANES-1:0][DREM_W-1:0]           drem;
        logic [LANES-1:0][QUO_W-1:0]            quo;
        logic [LANES-1:0][DATA_W-1:0]           rv;
        logic [DATA_W-1:0]                      sc;
        logic                                   zl;
        logic                                   ov;
    } pipe_t;

    // saturate to DATA_W bits; MSB of the result is the overflow flag
    function automatic logic [DATA_W:0] sat_val(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-DATA_W:0] hi;
        logic [DATA_W:0]        r;
        hi = v[WIDE_W-1:DATA_W-1];
        r  = {1'b0, v[DATA_W-1:0]};
        if (!((&hi) || (~|hi)))
        begin
            if (v[WIDE_W-1])
                r = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
            else
                r = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### src/tva_req_if.sv
// ----------------------------------------------------------------------------
// tva_req_if: request channel
// Valid/ready channel carrying one command with vectors A, B and a scale.
// ----------------------------------------------------------------------------
interface tva_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale_factor;

    modport src  (output valid, command, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
                  input ready);
    modport sink (input valid, command, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
                  output ready);
endinterface

### src/tva_rsp_if.sv
// ----------------------------------------------------------------------------
// tva_rsp_if: response channel
// Valid/ready channel carrying the result vector, scalar and flags.
// ----------------------------------------------------------------------------
interface tva_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_scalar;
    logic               zero_length;
    logic               overflow;

    modport src  (output valid, res_x, res_y, res_z, res_scalar, zero_length, overflow,
                  input ready);
    modport sink (input valid, res_x, res_y, res_z, res_scalar, zero_length, overflow,
                  output ready);
endinterface

### src/tva_front.sv
// ----------------------------------------------------------------------------
// tva_front: multiply and reduce stages
// Stage 1 forms all products and sums, stage 2 reduces, floors and saturates.
// ----------------------------------------------------------------------------
module tva_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [2:0]                             cmd,
    input  logic [tva_pkg::LANES-1:0][31:0]        a,
    input  logic [tva_pkg::LANES-1:0][31:0]        b,
    input  logic [31:0]                            s,
    output logic                                   out_valid,
    output tva_pkg::pipe_t                         out
);

    logic                                          v1_reg;
    logic [2:0]                                    cmd1_reg;
    logic [tva_pkg::LANES-1:0][63:0]               sq_reg;
    logic signed [63:0]                            dp_reg [tva_pkg::LANES];
    logic signed [63:0]                            sp_reg [tva_pkg::LANES];
    logic signed [32:0]                            sm_reg [tva_pkg::LANES];
    logic [tva_pkg::LANES-1:0][31:0]               mag_reg;
    logic [tva_pkg::LANES-1:0]                     neg_reg;
    logic [tva_pkg::LANES-1:0][31:0]               mag_next;

    logic                                          v2_reg;
    tva_pkg::pipe_t                                p2_reg;
    tva_pkg::pipe_t                                p2_next;

    // magnitudes of A for squares and normalize
    always_comb
    begin
        for (int i = 0; i < tva_pkg::LANES; i++)
            mag_next[i] = a[i][31] ? (32'd0 - a[i]) : a[i];
    end

    // stage 1: products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg <= cmd;
            mag_reg  <= mag_next;
            for (int i = 0; i < tva_pkg::LANES; i++)
            begin
                neg_reg[i] <= a[i][31];
                sq_reg[i]  <= 64'(mag_next[i]) * 64'(mag_next[i]);
                dp_reg[i]  <= $signed(a[i]) * $signed(b[i]);
                sp_reg[i]  <= $signed(a[i]) * $signed(s);
                sm_reg[i]  <= $signed(a[i]) + $signed(b[i]);
            end
        end
    end

    // stage 2: reduce and saturate
    always_comb
    begin
        logic signed [tva_pkg::WIDE_W-1:0] dsum;
        logic [tva_pkg::DATA_W:0]          sv;
        logic                              ov;
        p2_next      = '0;
        p2_next.cmd  = cmd1_reg;
        p2_next.rad  = sq_reg[0] + sq_reg[1] + sq_reg[2];
        p2_next.mag  = mag_reg;
        p2_next.neg  = neg_reg;
        ov   = 1'b0;
        sv   = '0;
        dsum = tva_pkg::WIDE_W'(dp_reg[0]) + tva_pkg::WIDE_W'(dp_reg[1])
             + tva_pkg::WIDE_W'(dp_reg[2]);
        case (cmd1_reg)
            tva_pkg::CMD_DOT:
            begin
                sv = tva_pkg::sat_val(dsum >>> tva_pkg::FRAC_BITS);
                p2_next.sc = sv[tva_pkg::DATA_W-1:0];
                ov = sv[tva_pkg::DATA_W];
            end
            tva_pkg::CMD_SCALE:
            begin
                for (int i = 0; i < tva_pkg::LANES; i++)
                begin
                    sv = tva_pkg::sat_val(tva_pkg::WIDE_W'(sp_reg[i] >>> tva_pkg::FRAC_BITS));
                    p2_next.rv[i] = sv[tva_pkg::DATA_W-1:0];
                    ov = ov | sv[tva_pkg::DATA_W];
                end
            end
            tva_pkg::CMD_ADD:
            begin
                for (int i = 0; i < tva_pkg::LANES; i++)
                begin
                    sv = tva_pkg::sat_val(tva_pkg::WIDE_W'(sm_reg[i]));
                    p2_next.rv[i] = sv[tva_pkg::DATA_W-1:0];
                    ov = ov | sv[tva_pkg::DATA_W];
                end
            end
            default:
            begin
                ov = 1'b0;
            end
        endcase
        p2_next.ov = ov;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p2_reg <= p2_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out       = p2_reg;

endmodule

### src/tva_sqrt_step.sv
// ----------------------------------------------------------------------------
// tva_sqrt_step: one bit of the integer square root
// Tests one root bit against the remaining radicand and registers the record.
// ----------------------------------------------------------------------------
module tva_sqrt_step (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic [tva_pkg::ROOT_IDX_W-1:0]    bit_idx,
    input  logic                              in_valid,
    input  tva_pkg::pipe_t                    in,
    output logic                              out_valid,
    output tva_pkg::pipe_t                    out
);

    localparam int TW = tva_pkg::RAD_W + 2;

    logic           v_reg;
    tva_pkg::pipe_t p_reg;
    tva_pkg::pipe_t p_next;

    // trial = 2*root*2^b + 2^(2b)
    always_comb
    begin
        logic [TW-1:0] trial;
        logic [TW-1:0] rem;
        trial  = (TW'(in.root) << (int'(bit_idx) + 1)) | (TW'(1) << (2 * int'(bit_idx)));
        rem    = TW'(in.rad);
        p_next = in;
        if (rem >= trial)
        begin
            p_next.rad  = tva_pkg::RAD_W'(rem - trial);
            p_next.root = in.root | (tva_pkg::ROOT_W'(1) << bit_idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= p_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    assign out_valid = v_reg;
    assign out       = p_reg;

endmodule

### src/tva_div_step.sv
// ----------------------------------------------------------------------------
// tva_div_step: one quotient bit of the normalize divide
// Three lanes of restoring division by the length, one bit per stage.
// ----------------------------------------------------------------------------
module tva_div_step (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic [tva_pkg::DIV_IDX_W-1:0]     bit_idx,
    input  logic                              in_valid,
    input  tva_pkg::pipe_t                    in,
    output logic                              out_valid,
    output tva_pkg::pipe_t                    out
);

    logic           v_reg;
    tva_pkg::pipe_t p_reg;
    tva_pkg::pipe_t p_next;

    // compare each lane's remainder against len shifted to this bit
    always_comb
    begin
        logic [tva_pkg::DREM_W-1:0] trial;
        trial  = tva_pkg::DREM_W'(in.root) << bit_idx;
        p_next = in;
        for (int i = 0; i < tva_pkg::LANES; i++)
        begin
            if (in.drem[i] >= trial)
            begin
                p_next.drem[i] = in.drem[i] - trial;
                p_next.quo[i]  = in.quo[i] | (tva_pkg::QUO_W'(1) << bit_idx);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= p_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    assign out_valid = v_reg;
    assign out       = p_reg;

endmodule

### src/three_vector_alu_core.sv
// ----------------------------------------------------------------------------
// three_vector_alu_core: pipelined Q16.16 vector unit
// Length, normalize, dot, scale and add on 3-component fixed-point vectors.
// ----------------------------------------------------------------------------
// Every command takes the same Q16.16 path through all stages.
// Throughput: one beat per cycle unless stalled; 32 square-root stages and
// 17 divide stages each retire one bit, so those two chains set the depth.
// The whole pipeline holds while a finished beat waits at the output.
// Reset clears every valid bit; no payload is reset.
module three_vector_alu_core (
    input  logic     clk,
    input  logic     rst_n,
    tva_req_if.sink  req,
    tva_rsp_if.src   rsp
);

    localparam int NS = tva_pkg::ROOT_W;
    localparam int ND = tva_pkg::QUO_W;

    logic                                  en;
    logic [tva_pkg::LANES-1:0][31:0]       a_vec;
    logic [tva_pkg::LANES-1:0][31:0]       b_vec;

    logic                                  sv [NS+1];
    tva_pkg::pipe_t                        sp [NS+1];
    logic                                  dv [ND+1];
    tva_pkg::pipe_t                        dp [ND+1];

    logic                                  out_valid_reg;
    logic [tva_pkg::LANES-1:0][31:0]       rv_reg;
    logic [31:0]                           sc_reg;
    logic                                  zl_reg;
    logic                                  ov_reg;
    tva_pkg::pipe_t                        fin_next;

    // global advance: move unless a finished beat is stuck
    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    assign a_vec = {req.a_z, req.a_y, req.a_x};
    assign b_vec = {req.b_z, req.b_y, req.b_x};

    tva_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .cmd       (req.command),
        .a         (a_vec),
        .b         (b_vec),
        .s         (req.scale_factor),
        .out_valid (sv[0]),
        .out       (sp[0])
    );

    // square root chain, MSB first
    for (genvar g = 0; g < NS; g++)
    begin : g_sqrt
        tva_sqrt_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .bit_idx   (tva_pkg::ROOT_IDX_W'(NS - 1 - g)),
            .in_valid  (sv[g]),
            .in        (sp[g]),
            .out_valid (sv[g+1]),
            .out       (sp[g+1])
        );
    end

    // load dividends |a| * 2^FRAC_BITS
    always_comb
    begin
        dp[0] = sp[NS];
        dv[0] = sv[NS];
        for (int i = 0; i < tva_pkg::LANES; i++)
        begin
            dp[0].drem[i] = {sp[NS].mag[i], {tva_pkg::FRAC_BITS{1'b0}}};
            dp[0].quo[i]  = '0;
        end
    end

    // divide chain, MSB first
    for (genvar g = 0; g < ND; g++)
    begin : g_div
        tva_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .bit_idx   (tva_pkg::DIV_IDX_W'(ND - 1 - g)),
            .in_valid  (dv[g]),
            .in        (dp[g]),
            .out_valid (dv[g+1]),
            .out       (dp[g+1])
        );
    end

    // final formatting of length and normalize results
    always_comb
    begin
        fin_next = dp[ND];
        case (dp[ND].cmd)
            tva_pkg::CMD_LENGTH:
            begin
                fin_next.sc = dp[ND].root[31] ? 32'h7fff_ffff : dp[ND].root;
                fin_next.ov = dp[ND].root[31];
            end
            tva_pkg::CMD_NORMALIZE:
            begin
                if (dp[ND].root == '0)
                begin
                    fin_next.zl = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < tva_pkg::LANES; i++)
                        fin_next.rv[i] = dp[ND].neg[i] ? (32'd0 - 32'(dp[ND].quo[i]))
                                                       : 32'(dp[ND].quo[i]);
                end
            end
            default:
            begin
                fin_next.zl = 1'b0;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rv_reg <= fin_next.rv;
            sc_reg <= fin_next.sc;
            zl_reg <= fin_next.zl;
            ov_reg <= fin_next.ov;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv[ND];
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.res_x       = rv_reg[0];
    assign rsp.res_y       = rv_reg[1];
    assign rsp.res_z       = rv_reg[2];
    assign rsp.res_scalar  = sc_reg;
    assign rsp.zero_length = zl_reg;
    assign rsp.overflow    = ov_reg;

    // a zero-length normalize returns the zero vector without overflow
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.zero_length |->
            rsp.res_x == 0 && rsp.res_y == 0 && rsp.res_z == 0 && !rsp.overflow)
        else $error("zero_length beat with nonzero result");

    // overflow only when some field sits on a saturation rail
    a_ovf_rail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.overflow |->
            rsp.res_x == 32'sh7fff_ffff || rsp.res_x == 32'sh8000_0000 ||
            rsp.res_y == 32'sh7fff_ffff || rsp.res_y == 32'sh8000_0000 ||
            rsp.res_z == 32'sh7fff_ffff || rsp.res_z == 32'sh8000_0000 ||
            rsp.res_scalar == 32'sh7fff_ffff || rsp.res_scalar == 32'sh8000_0000)
        else $error("overflow flag without saturated field");

    // a held output beat freezes the whole pipeline
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> $stable(dv[ND]) && $stable(sv[0]))
        else $error("pipeline advanced during output stall");

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the three-vector ALU core
// Drives commands with random idle gaps, predicts each result in the bench,
// and compares every response beat field by field against the oldest one.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, scale_factor;
    } vec_op_t;

    typedef struct packed {
        logic signed [31:0] res_x, res_y, res_z, res_scalar;
        logic               zero_length, overflow;
    } vec_res_t;

    localparam int LATENCY = 60;

    logic clk;
    logic rst_n;
    int   errors;
    bit   stim_done;
    int   rsp_hold;     // long receiver hold-off, in cycles
    vec_res_t expected_results[$];

    tva_req_if req ();
    tva_rsp_if rsp ();

    three_vector_alu_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.src)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // timeout
    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    // floor(v / 2^FRAC_BITS); >>> on a signed value floors
    function automatic logic signed [127:0] fl_shift(input logic signed [127:0] v);
        return v >>> tva_pkg::FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                   inout logic ov);
        if (v > 128'sd2147483647)
        begin
            ov = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -128'sd2147483648)
        begin
            ov = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        return r;
    endfunction

    // predicted result of one command
    function automatic vec_res_t compute_vector_op(input vec_op_t op);
        vec_res_t r;
        logic signed [127:0] a [3];
        logic signed [127:0] b [3];
        logic signed [127:0] s, acc, q;
        logic signed [31:0]  rv [3];
        logic [63:0] sum, len;
        logic ov;
        r = '0;
        ov = 1'b0;
        a[0] = op.a_x; a[1] = op.a_y; a[2] = op.a_z;
        b[0] = op.b_x; b[1] = op.b_y; b[2] = op.b_z;
        s = op.scale_factor;
        rv[0] = 0; rv[1] = 0; rv[2] = 0;
        case (op.command)
            tva_pkg::CMD_LENGTH, tva_pkg::CMD_NORMALIZE:
            begin
                sum = 0;
                for (int i = 0; i < 3; i++)
                    sum += 64'(a[i] * a[i]);
                len = int_sqrt(sum);
                if (op.command == tva_pkg::CMD_LENGTH)
                    r.res_scalar = clamp32($signed({64'd0, len}), ov);
                else if (len == 0)
                    r.zero_length = 1'b1;
                else
                    for (int i = 0; i < 3; i++)
                    begin
                        // signed division truncates toward zero
                        q = (a[i] <<< tva_pkg::FRAC_BITS) / $signed({64'd0, len});
                        rv[i] = clamp32(q, ov);
                    end
            end
            tva_pkg::CMD_DOT:
            begin
                acc = 0;
                for (int i = 0; i < 3; i++)
                    acc += a[i] * b[i];
                r.res_scalar = clamp32(fl_shift(acc), ov);
            end
            tva_pkg::CMD_SCALE:
                for (int i = 0; i < 3; i++)
                    rv[i] = clamp32(fl_shift(a[i] * s), ov);
            tva_pkg::CMD_ADD:
                for (int i = 0; i < 3; i++)
                    rv[i] = clamp32(a[i] + b[i], ov);
            default: ;
        endcase
        r.res_x = rv[0];
        r.res_y = rv[1];
        r.res_z = rv[2];
        r.overflow = ov;
        return r;
    endfunction

    // send one beat after a random gap unless no_gap is set; valid stays up for a following beat
    task automatic send_op(input vec_op_t op, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.command      <= op.command;
        req.a_x          <= op.a_x;
        req.a_y          <= op.a_y;
        req.a_z          <= op.a_z;
        req.b_x          <= op.b_x;
        req.b_y          <= op.b_y;
        req.b_z          <= op.b_z;
        req.scale_factor <= op.scale_factor;
        expected_results.push_back(compute_vector_op(op));
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // drop valid at the end of a burst
    task automatic idle_req();
        req.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
            4: return $urandom_range(0, 32'hfff) - 32'h7ff;
            default: return $urandom;
        endcase
    endfunction

    function automatic vec_op_t rand_op();
        vec_op_t op;
        op.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
        op.a_x = rand_val(); op.a_y = rand_val(); op.a_z = rand_val();
        op.b_x = rand_val(); op.b_y = rand_val(); op.b_z = rand_val();
        op.scale_factor = rand_val();
        if ($urandom_range(0, 9) == 0)
        begin
            op.a_x = 0; op.a_y = 0; op.a_z = 0;
        end
        return op;
    endfunction

    function automatic vec_op_t mk_op(input logic [2:0] c, input logic [31:0] ax,
                                      ay, az, bx, by, bz, sf);
        vec_op_t op;
        op.command = c;
        op.a_x = ax; op.a_y = ay; op.a_z = az;
        op.b_x = bx; op.b_y = by; op.b_z = bz;
        op.scale_factor = sf;
        return op;
    endfunction

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // extremes, every command, zero vector, unit length, unknown commands
    task automatic test_directed();
        localparam logic [31:0] MX = 32'h7fffffff;
        localparam logic [31:0] MN = 32'h80000000;
        localparam logic [31:0] ONE = 32'h00010000;
        send_op(mk_op(tva_pkg::CMD_LENGTH, MX, MX, MX, 0, 0, 0, 0));
        send_op(mk_op(tva_pkg::CMD_LENGTH, MN, MN, MN, 0, 0, 0, 0));
        send_op(mk_op(tva_pkg::CMD_LENGTH, ONE, 0, 0, 0, 0, 0, 0));
        send_op(mk_op(tva_pkg::CMD_NORMALIZE, 0, 0, 0, MX, MX, MX, MX));
        send_op(mk_op(tva_pkg::CMD_NORMALIZE, ONE, 0, 0, 0, 0, 0, 0));
        send_op(mk_op(tva_pkg::CMD_NORMALIZE, 0, MN, 0, 0, 0, 0, 0));
        send_op(mk_op(tva_pkg::CMD_NORMALIZE, MX, MN, 1, 0, 0, 0, 0));
        send_op(mk_op(tva_pkg::CMD_NORMALIZE, 1, 0, 0, 0, 0, 0, 0));
        send_op(mk_op(tva_pkg::CMD_DOT, MX, MX, MX, MX, MX, MX, 0));
        send_op(mk_op(tva_pkg::CMD_DOT, MN, MN, MN, MX, MX, MX, 0));
        send_op(mk_op(tva_pkg::CMD_DOT, -1, 1, 0, 1, 1, 0, 0));
        send_op(mk_op(tva_pkg::CMD_SCALE, MX, MN, -1, 0, 0, 0, MX));
        send_op(mk_op(tva_pkg::CMD_SCALE, MN, MN, 1, 0, 0, 0, MN));
        send_op(mk_op(tva_pkg::CMD_SCALE, ONE, -1, 3, 0, 0, 0, -1));
        send_op(mk_op(tva_pkg::CMD_ADD, MX, MN, 0, MX, MN, 0, 0));
        send_op(mk_op(tva_pkg::CMD_ADD, MX, MN, -1, -1, 1, 1, 0));
        send_op(mk_op(3'd5, MX, MX, MX, MX, MX, MX, MX));
        send_op(mk_op(3'd6, 1, 2, 3, 4, 5, 6, 7));
        send_op(mk_op(3'd7, MN, MN, MN, MN, MN, MN, MN));
    endtask

    // random stream with random gaps on both sides
    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_op(rand_op(), (i % 200) < 40);
    endtask

    // receiver holds off long; sender keeps pushing until the input stalls
    task automatic test_backpressure();
        rsp_hold = 300;
        for (int i = 0; i < 100; i++)
            send_op(rand_op(), 1);
        idle_req();
        wait_drained();
    endtask

    // stimulus
    initial
    begin
        req.valid = 1'b0;
        req.command = '0;
        req.a_x = '0; req.a_y = '0; req.a_z = '0;
        req.b_x = '0; req.b_y = '0; req.b_z = '0;
        req.scale_factor = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(500);
        idle_req();
        wait_drained();
        test_backpressure();
        test_random(530);
        idle_req();
        stim_done = 1'b1;
    end

    // response ready with random stalls and an occasional long hold-off
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rsp_hold > 0)
            begin
                stall = rsp_hold;
                rsp_hold = 0;
            end
            else
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        vec_res_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with no expectation pending");
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (rsp.res_x !== e.res_x)
                begin
                    $error("res_x expected %h got %h", e.res_x, rsp.res_x);
                    errors++;
                end
                if (rsp.res_y !== e.res_y)
                begin
                    $error("res_y expected %h got %h", e.res_y, rsp.res_y);
                    errors++;
                end
                if (rsp.res_z !== e.res_z)
                begin
                    $error("res_z expected %h got %h", e.res_z, rsp.res_z);
                    errors++;
                end
                if (rsp.res_scalar !== e.res_scalar)
                begin
                    $error("res_scalar expected %h got %h", e.res_scalar, rsp.res_scalar);
                    errors++;
                end
                if (rsp.zero_length !== e.zero_length)
                begin
                    $error("zero_length expected %b got %b", e.zero_length,
                           rsp.zero_length);
                    errors++;
                end
                if (rsp.overflow !== e.overflow)
                begin
                    $error("overflow expected %b got %b", e.overflow, rsp.overflow);
                    errors++;
                end
            end
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        wait_drained();
        repeat (LATENCY) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
